/* hdl/npcm_pkg.sv */
// Shared types and constants for the nearest palette color match block.
// Used by the controller, the datapath and the top level; no dependencies.
package npcm_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int SIZE_W            = 9;
    localparam int COLOR_W           = 16;
    localparam int CODE_W            = 8;
    localparam int INDEX_W           = 8;
    localparam int DIST_W            = 18;
    localparam int ENTRY_W           = 3 * COLOR_W + CODE_W;
    localparam int PADDR_W           = 2;

    localparam logic [SIZE_W-1:0] PALETTE_SIZE_RST = 9'd256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_en;
        logic capture;
        logic rd_en;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

endpackage

/* hdl/npcm_datapath.sv */
// Datapath: palette memory, distance pipeline and best-match registers.
// Depends on npcm_pkg; driven by npcm_ctrl through t_dp_cmd.
module npcm_datapath
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int AW = $clog2(PALETTE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic [CODE_W-1:0]  i_pixel_code,
    input  logic [CODE_W-1:0]  i_fallback_pixel,
    output t_dp_status         o_status,
    output logic [CODE_W-1:0]  o_matched_pixel,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_found
);

    logic [ENTRY_W-1:0] r_mem [PALETTE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_v1;
    logic               r_v2;
    logic [COLOR_W-1:0] r_qr, r_qg, r_qb;
    logic [DIST_W-1:0]  r_dist;
    logic [CODE_W-1:0]  r_code;
    logic [CODE_W-1:0]  r_best_pix;
    logic [DIST_W-1:0]  r_best_dist;
    logic               r_have;

    logic               wr_ok;
    logic [COLOR_W-1:0] m_red, m_green, m_blue;
    logic [COLOR_W-1:0] d_red, d_green, d_blue;
    logic [DIST_W-1:0]  n_dist;
    logic               take;

    assign wr_ok = (32'(i_entry_index) < 32'(PALETTE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && wr_ok) begin
            r_mem[AW'(i_entry_index)] <= {i_red, i_green, i_blue, i_pixel_code};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign m_red   = r_rdata[ENTRY_W-1 -: COLOR_W];
    assign m_green = r_rdata[ENTRY_W-1-COLOR_W -: COLOR_W];
    assign m_blue  = r_rdata[CODE_W +: COLOR_W];

    assign d_red   = (r_qr >= m_red)   ? (r_qr - m_red)   : (m_red - r_qr);
    assign d_green = (r_qg >= m_green) ? (r_qg - m_green) : (m_green - r_qg);
    assign d_blue  = (r_qb >= m_blue)  ? (r_qb - m_blue)  : (m_blue - r_qb);
    assign n_dist  = DIST_W'(d_red) + DIST_W'(d_green) + DIST_W'(d_blue);

    // strict less-than keeps the lowest index on a tie
    assign take = r_v2 && (!r_have || (r_dist < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.capture) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qr        <= i_red;
            r_qg        <= i_green;
            r_qb        <= i_blue;
            r_best_pix  <= i_fallback_pixel;
            r_best_dist <= '0;
        end else if (take) begin
            r_best_pix  <= r_code;
            r_best_dist <= r_dist;
        end
        if (r_v1) begin
            r_dist <= n_dist;
            r_code <= r_rdata[CODE_W-1:0];
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_matched_pixel    = r_best_pix;
    assign o_distance         = r_best_dist;
    assign o_found            = r_have;

endmodule

/* hdl/npcm_ctrl.sv */
// Controller: accepts words, sequences the palette scan and flags the result.
// Depends on npcm_pkg; drives npcm_datapath through t_dp_cmd.
module npcm_ctrl
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    localparam int AW = $clog2(PALETTE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_command,
    input  logic [SIZE_W-1:0] i_palette_size,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd,
    output logic [AW-1:0]     o_rd_addr,
    output logic              busy,
    output logic              o_valid
);

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_last, n_last;
    logic          accept;

    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_last        = r_last;
        o_cmd.load_en = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.rd_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_LOAD)) begin
                    o_cmd.load_en = 1'b1;
                end else if (accept && (i_command == CMD_QUERY)) begin
                    o_cmd.capture = 1'b1;
                    n_addr        = '0;
                    // clamp the search to the store size
                    if (32'(i_palette_size) > 32'(PALETTE_DEPTH)) begin
                        n_last = AW'(PALETTE_DEPTH - 1);
                    end else begin
                        n_last = AW'(32'(i_palette_size) - 32'd1);
                    end
                    n_state = (i_palette_size == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + 1'b1;
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_last <= n_last;
    end

    assign o_rd_addr = r_addr;
    assign busy      = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_DONE);

endmodule

/* hdl/nearest_palette_color_match.sv */
// Nearest palette color match: a load word writes one palette entry at the accepting edge
// and leaves busy low. A query word scans entries 0 to min(palette_size, PALETTE_DEPTH)-1,
// one memory read per cycle, through a three-stage read/distance/compare pipeline; o_valid
// rises once the last entry has passed the pipeline (in the very next cycle when palette_size
// is zero, as the scan is skipped) and holds for one cycle, and busy stays high until that
// strobe ends. The single memory read port sets the one-entry-per-cycle scan. Results cannot
// be held off: capture them in the cycle o_valid is high.
// Depends on npcm_pkg, npcm_ctrl and npcm_datapath.
module nearest_palette_color_match
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic [CODE_W-1:0]  i_pixel_code,
    input  logic [CODE_W-1:0]  i_fallback_pixel,
    output logic               o_valid,
    output logic [CODE_W-1:0]  o_matched_pixel,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_found
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [SIZE_W-1:0] r_palette_size;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;
    logic [AW-1:0]     rd_addr;

    // single register: every write lands in palette_size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= PALETTE_SIZE_RST;
        end else if (psel && penable && pwrite && pready) begin
            r_palette_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? 32'(r_palette_size) : '0;

    npcm_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .i_palette_size (r_palette_size),
        .i_status       (dp_status),
        .o_cmd          (dp_cmd),
        .o_rd_addr      (rd_addr),
        .busy           (busy),
        .o_valid        (o_valid)
    );

    npcm_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_rd_addr        (rd_addr),
        .i_entry_index    (i_entry_index),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_pixel_code     (i_pixel_code),
        .i_fallback_pixel (i_fallback_pixel),
        .o_status         (dp_status),
        .o_matched_pixel  (o_matched_pixel),
        .o_distance       (o_distance),
        .o_found          (o_found)
    );

endmodule

/* hdl/npcm_checker.sv */
// Port-level checks for nearest_palette_color_match, attached by bind.
// Depends on npcm_pkg and the top level's port list.
module npcm_checker
    import npcm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_command,
    input logic               o_valid,
    input logic [DIST_W-1:0]  o_distance,
    input logic               o_found
);

    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a query");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe longer than one cycle");

    a_empty_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_distance == '0))
        else $error("empty search with nonzero distance");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_QUERY)) |=> busy)
        else $error("query accepted without going busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_LOAD)) |=> !busy)
        else $error("load word stalled the block");

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (.*);
